// File: rtl/arwb_pkg.sv
// Package of types, codes and defaults for the anti-replay window bank.
`default_nettype none
package arwb_pkg;

    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 8;
    localparam int COUNTER_W = 64;
    localparam int VERDICT_W = 2;

    localparam int CONTEXTS_DEF = 256;
    localparam int WINDOW_DEF   = 64;

    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [COUNTER_W-1:0] t_counter;
    typedef logic [VERDICT_W-1:0] t_verdict;

    localparam t_cmd CMD_CHECK  = 2'd0;
    localparam t_cmd CMD_COMMIT = 2'd1;
    localparam t_cmd CMD_CLEAR  = 2'd2;

    localparam t_verdict VERDICT_OK     = 2'd0;
    localparam t_verdict VERDICT_REPLAY = 2'd1;
    localparam t_verdict VERDICT_FORGED = 2'd2;

    localparam t_counter LIMIT_RESET = '1;

    typedef struct packed {
        logic     wr_en;
        t_verdict verdict;
    } t_upd;

endpackage
`default_nettype wire

// File: rtl/arwb_store.sv
// Window memories: highest accepted counter and seen bitmap for each context.
`default_nettype none
module arwb_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int WW    = 64
) (
    input  wire logic                     i_clk,
    input  wire logic [AW-1:0]            i_rd_addr,
    output logic      [arwb_pkg::COUNTER_W-1:0] o_rd_top,
    output logic      [WW-1:0]            o_rd_seen,
    input  wire logic                     i_wr_en,
    input  wire logic [AW-1:0]            i_wr_addr,
    input  wire logic [arwb_pkg::COUNTER_W-1:0] i_wr_top,
    input  wire logic [WW-1:0]            i_wr_seen
);
    import arwb_pkg::*;

    t_counter          mem_top [DEPTH];
    logic     [WW-1:0] mem_seen [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_top[i_wr_addr]  <= i_wr_top;
            mem_seen[i_wr_addr] <= i_wr_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_top  <= mem_top[i_rd_addr];
        o_rd_seen <= mem_seen[i_rd_addr];
    end

endmodule
`default_nettype wire

// File: rtl/arwb_eval.sv
// Compare stage and update logic that decide the verdict and the new window.
`default_nettype none
module arwb_eval #(
    parameter int WINDOW = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_cmp_en,
    input  wire logic [arwb_pkg::CMD_W-1:0]  i_cmd,
    input  wire logic                        i_slot_ok,
    input  wire logic [arwb_pkg::COUNTER_W-1:0] i_ctr,
    input  wire logic [arwb_pkg::COUNTER_W-1:0] i_limit,
    input  wire logic [arwb_pkg::COUNTER_W-1:0] i_rd_top,
    input  wire logic [WINDOW-1:0]           i_rd_seen,
    output arwb_pkg::t_upd                   o_ctl,
    output logic      [arwb_pkg::COUNTER_W-1:0] o_new_top,
    output logic      [WINDOW-1:0]           o_new_seen
);
    import arwb_pkg::*;

    localparam int DW = $clog2(WINDOW);

    t_counter          lag;
    t_counter          up;
    logic              r_forged;
    logic              r_le;
    logic              r_dist_far;
    logic     [DW-1:0] r_dist_lo;
    logic              r_up_far;
    logic     [DW-1:0] r_up_lo;
    t_counter          r_top;
    logic [WINDOW-1:0] r_seen;
    logic              hit;
    logic              commit_ok;
    t_verdict          verdict;

    assign lag = i_rd_top - i_ctr;
    assign up  = i_ctr - i_rd_top;

    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_forged   <= i_ctr > i_limit;
            r_le       <= i_ctr <= i_rd_top;
            r_dist_far <= lag >= COUNTER_W'(WINDOW);
            r_dist_lo  <= lag[DW-1:0];
            r_up_far   <= up >= COUNTER_W'(WINDOW);
            r_up_lo    <= up[DW-1:0];
            r_top      <= i_rd_top;
            r_seen     <= i_rd_seen;
        end
    end

    assign hit = r_seen[r_dist_lo];

    always_comb begin
        if (!i_slot_ok) begin
            verdict = VERDICT_REPLAY;
        end else if (i_cmd == CMD_CLEAR) begin
            verdict = VERDICT_OK;
        end else if (r_forged) begin
            verdict = VERDICT_FORGED;
        end else if (r_le && (r_dist_far || hit)) begin
            verdict = VERDICT_REPLAY;
        end else begin
            verdict = VERDICT_OK;
        end
    end

    assign commit_ok = i_slot_ok && (i_cmd == CMD_COMMIT) && (verdict == VERDICT_OK);

    always_comb begin
        o_new_top  = r_top;
        o_new_seen = r_seen;
        if (!i_slot_ok || i_cmd == CMD_CLEAR) begin
            o_new_top  = '0;
            o_new_seen = '0;
        end else if (commit_ok) begin
            if (r_le) begin
                o_new_seen = r_seen | (WINDOW'(1) << r_dist_lo);
            end else begin
                o_new_top = i_ctr;
                if (r_up_far) begin
                    o_new_seen = WINDOW'(1);
                end else begin
                    o_new_seen = (r_seen << r_up_lo) | WINDOW'(1);
                end
            end
        end
    end

    assign o_ctl.wr_en   = (i_slot_ok && i_cmd == CMD_CLEAR) || commit_ok;
    assign o_ctl.verdict = verdict;

endmodule
`default_nettype wire

// File: rtl/anti_replay_window_bank_unit.sv
// Top level of the anti-replay window bank: sequencer, configuration and result beat.
// An item is taken when start is high and busy is low. The window memories are read at
// acceptance, the counter is compared against the limit and the stored top in the next
// cycle, and the verdict and new window are then written back in the S_UPD state. busy
// stays high through that write-back, and the result beat appears on o_result_valid
// in the cycle after that, for one cycle only; the receiver cannot stall it. After
// reset busy is held high while the memories are cleared one entry a cycle, through
// all CONTEXTS entries. The counter limit is written through the configuration
// channel, which is always ready; the user must write it only at a time when no item
// is in flight, as the block itself does not enforce it.
`default_nettype none
module anti_replay_window_bank_unit #(
    parameter int CONTEXTS = arwb_pkg::CONTEXTS_DEF,
    parameter int WINDOW   = arwb_pkg::WINDOW_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [arwb_pkg::CMD_W-1:0]     i_command,
    input  wire logic [arwb_pkg::SLOT_W-1:0]    i_context_slot,
    input  wire logic [arwb_pkg::COUNTER_W-1:0] i_counter,
    output logic                                o_result_valid,
    output logic      [arwb_pkg::VERDICT_W-1:0] o_verdict,
    output logic      [arwb_pkg::COUNTER_W-1:0] o_window_top,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [arwb_pkg::COUNTER_W-1:0] i_cfg_counter_limit
);
    import arwb_pkg::*;

    localparam int AW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [AW-1:0]     r_clr_addr;
    logic [AW-1:0]     n_clr_addr;
    t_counter          r_limit;
    t_cmd              r_cmd;
    logic              r_slot_ok;
    logic [AW-1:0]     r_addr;
    t_counter          r_ctr;
    logic              r_result_valid;
    t_verdict          r_verdict;
    t_counter          r_window_top;

    logic              accept;
    logic [AW-1:0]     rd_addr;
    t_counter          rd_top;
    logic [WINDOW-1:0] rd_seen;
    t_upd              upd;
    t_counter          new_top;
    logic [WINDOW-1:0] new_seen;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    t_counter          wr_top;
    logic [WINDOW-1:0] wr_seen;

    assign accept      = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        case (r_state)
            S_CLR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(CONTEXTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLR;
            r_clr_addr     <= '0;
            r_limit        <= LIMIT_RESET;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_clr_addr     <= n_clr_addr;
            r_result_valid <= (r_state == S_UPD);
            if (i_cfg_valid) begin
                r_limit <= i_cfg_counter_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_command;
            r_slot_ok <= 32'(i_context_slot) < CONTEXTS;
            r_addr    <= AW'(i_context_slot);
            r_ctr     <= i_counter;
        end
        if (r_state == S_UPD) begin
            r_verdict    <= upd.verdict;
            r_window_top <= new_top;
        end
    end

    assign rd_addr = AW'(i_context_slot);

    always_comb begin
        if (r_state == S_CLR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_top  = '0;
            wr_seen = '0;
        end else begin
            wr_en   = (r_state == S_UPD) && upd.wr_en;
            wr_addr = r_addr;
            wr_top  = new_top;
            wr_seen = new_seen;
        end
    end

    arwb_store #(
        .DEPTH (CONTEXTS),
        .AW    (AW),
        .WW    (WINDOW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_top  (rd_top),
        .o_rd_seen (rd_seen),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_top  (wr_top),
        .i_wr_seen (wr_seen)
    );

    arwb_eval #(
        .WINDOW (WINDOW)
    ) u_eval (
        .i_clk      (i_clk),
        .i_cmp_en   (r_state == S_CMP),
        .i_cmd      (r_cmd),
        .i_slot_ok  (r_slot_ok),
        .i_ctr      (r_ctr),
        .i_limit    (r_limit),
        .i_rd_top   (rd_top),
        .i_rd_seen  (rd_seen),
        .o_ctl      (upd),
        .o_new_top  (new_top),
        .o_new_seen (new_seen)
    );

    assign o_result_valid = r_result_valid;
    assign o_verdict      = r_verdict;
    assign o_window_top   = r_window_top;

endmodule
`default_nettype wire

// File: rtl/arwb_checker.sv
// Port-level checks on the anti-replay window bank and their binding to the top level.
`default_nettype none
module arwb_checker #(
    parameter int CONTEXTS = arwb_pkg::CONTEXTS_DEF
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic [arwb_pkg::CMD_W-1:0]     i_command,
    input wire logic [arwb_pkg::SLOT_W-1:0]    i_context_slot,
    input wire logic                           o_result_valid,
    input wire logic [arwb_pkg::VERDICT_W-1:0] o_verdict,
    input wire logic [arwb_pkg::COUNTER_W-1:0] o_window_top
);
    import arwb_pkg::*;

    logic clear_beat;

    assign clear_beat = start && !busy && (i_command == CMD_CLEAR)
                        && (32'(i_context_slot) < CONTEXTS);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted beat");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy) && !busy)
        else $error("result beat without a preceding busy interval");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_verdict == VERDICT_OK) || (o_verdict == VERDICT_REPLAY)
                           || (o_verdict == VERDICT_FORGED))
        else $error("unused verdict code on a result beat");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clear_beat |-> ##3 (o_result_valid && (o_verdict == VERDICT_OK)
                            && (o_window_top == '0)))
        else $error("clear beat did not return an accepted, empty window");

endmodule

bind anti_replay_window_bank_unit arwb_checker #(
    .CONTEXTS (CONTEXTS)
) u_arwb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_command      (i_command),
    .i_context_slot (i_context_slot),
    .o_result_valid (o_result_valid),
    .o_verdict      (o_verdict),
    .o_window_top   (o_window_top)
);
`default_nettype wire

// File: tb/sv/anti_replay_window_bank_unit_tb.sv
// Self-checking testbench for the anti-replay window bank: directed and random frame beats.
module anti_replay_window_bank_unit_tb;
    import arwb_pkg::*;

    localparam int       WIN         = WINDOW_DEF;
    localparam t_counter WIN_MASK    = (WIN >= 64) ? '1 : ((64'd1 << WIN) - 64'd1);
    localparam t_cmd     CMD_UNUSED  = 2'd3;
    localparam int       STALL_LIMIT = 2000;
    localparam int       HOT_SLOTS   = 6;

    typedef struct {
        bit       is_limit;
        bit       gap_ok;
        t_cmd     cmd;
        t_slot    slot;
        t_counter ctr;
    } frame_req_t;

    typedef struct {
        t_verdict verdict;
        t_counter top;
    } verdict_beat_t;

    logic     i_clk               = 1'b0;
    logic     i_rst_n             = 1'b0;
    logic     start               = 1'b0;
    t_cmd     i_command           = CMD_CHECK;
    t_slot    i_context_slot      = '0;
    t_counter i_counter           = '0;
    logic     i_cfg_valid         = 1'b0;
    t_counter i_cfg_counter_limit = '0;
    logic     busy;
    logic     o_result_valid;
    t_verdict o_verdict;
    t_counter o_window_top;
    logic     o_cfg_ready;

    anti_replay_window_bank_unit uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_command          (i_command),
        .i_context_slot     (i_context_slot),
        .i_counter          (i_counter),
        .o_result_valid     (o_result_valid),
        .o_verdict          (o_verdict),
        .o_window_top       (o_window_top),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_counter_limit(i_cfg_counter_limit)
    );

    wire item_taken  = start && (busy === 1'b0);
    wire limit_taken = i_cfg_valid && (o_cfg_ready === 1'b1);

    frame_req_t    req_q[$];
    verdict_beat_t awaited_verdicts[$];

    t_counter slot_top  [CONTEXTS_DEF];
    t_counter slot_seen [CONTEXTS_DEF];
    t_counter live_limit = LIMIT_RESET;

    t_counter guess_top [CONTEXTS_DEF];
    t_counter guess_limit = LIMIT_RESET;

    int mismatches = 0;
    int stall      = 0;
    int quiet      = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic verdict_beat_t judge_frame(input t_cmd cmd, input t_slot slot,
                                                  input t_counter ctr);
        verdict_beat_t res;
        t_counter      top;
        t_counter      seen;
        t_counter      lag;
        top  = slot_top[slot];
        seen = slot_seen[slot] & WIN_MASK;
        if (cmd == CMD_CLEAR) begin
            slot_top[slot]  = '0;
            slot_seen[slot] = '0;
            res.verdict     = VERDICT_OK;
            res.top         = '0;
            return res;
        end
        if (ctr > live_limit) begin
            res.verdict = VERDICT_FORGED;
        end else if (ctr <= top) begin
            lag = top - ctr;
            if (lag >= WIN || seen[lag[5:0]])
                res.verdict = VERDICT_REPLAY;
            else
                res.verdict = VERDICT_OK;
        end else begin
            res.verdict = VERDICT_OK;
        end
        if (cmd == CMD_COMMIT && res.verdict == VERDICT_OK) begin
            if (ctr > top) begin
                lag = ctr - top;
                if (lag >= WIN)
                    seen = 64'd1;
                else
                    seen = ((seen << lag) | 64'd1) & WIN_MASK;
                top = ctr;
            end else begin
                seen = seen | (64'd1 << (top - ctr));
            end
            slot_top[slot]  = top;
            slot_seen[slot] = seen;
        end
        res.top = top;
        return res;
    endfunction

    task automatic add_frame(input t_cmd cmd, input t_slot slot, input t_counter ctr,
                             input bit gap_ok);
        frame_req_t r;
        r.is_limit = 1'b0;
        r.gap_ok   = gap_ok;
        r.cmd      = cmd;
        r.slot     = slot;
        r.ctr      = ctr;
        req_q.push_back(r);
        if (cmd == CMD_CLEAR)
            guess_top[slot] = '0;
        else if (cmd == CMD_COMMIT && ctr <= guess_limit && ctr > guess_top[slot])
            guess_top[slot] = ctr;
    endtask

    task automatic add_limit(input t_counter value);
        frame_req_t r;
        r.is_limit = 1'b1;
        r.gap_ok   = 1'b1;
        r.cmd      = CMD_CHECK;
        r.slot     = '0;
        r.ctr      = value;
        req_q.push_back(r);
        guess_limit = value;
    endtask

    task automatic add_random_frame(input bit gap_ok);
        int       p;
        int       q;
        t_cmd     cmd;
        t_slot    slot;
        t_counter ctr;
        p = $urandom_range(0, 99);
        if (p < 85)
            slot = t_slot'($urandom_range(0, HOT_SLOTS - 1) * 51);
        else
            slot = t_slot'($urandom_range(0, 255));
        p = $urandom_range(0, 99);
        if (p < 4)
            cmd = CMD_CLEAR;
        else if (p < 10)
            cmd = CMD_UNUSED;
        else if (p < 60)
            cmd = CMD_COMMIT;
        else
            cmd = CMD_CHECK;
        q = $urandom_range(0, 99);
        if (q < 70)
            ctr = guess_top[slot] + t_counter'($urandom_range(0, 140)) - 64'd70;
        else if (q < 80)
            ctr = guess_top[slot] + t_counter'($urandom_range(64, 5000));
        else if (q < 90)
            ctr = {$urandom, $urandom};
        else
            ctr = guess_limit + t_counter'($urandom_range(0, 2)) - 64'd1;
        add_frame(cmd, slot, ctr, gap_ok);
    endtask

    always @(posedge i_clk) begin : driver
        bit         hold;
        bit         gap;
        frame_req_t r;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
            quiet       <= 0;
        end else begin
            if (!start && !i_cfg_valid && awaited_verdicts.size() == 0)
                quiet <= (quiet < 16) ? quiet + 1 : quiet;
            else
                quiet <= 0;
            hold = (start && !item_taken) || (i_cfg_valid && !limit_taken);
            gap  = req_q.size() != 0 && req_q[0].gap_ok && $urandom_range(0, 99) < 20;
            if (!hold) begin
                if (req_q.size() == 0 || gap) begin
                    start       <= 1'b0;
                    i_cfg_valid <= 1'b0;
                end else if (req_q[0].is_limit) begin
                    start <= 1'b0;
                    if (quiet >= 4 && busy === 1'b0 && !i_cfg_valid) begin
                        r = req_q.pop_front();
                        i_cfg_counter_limit <= r.ctr;
                        i_cfg_valid         <= 1'b1;
                    end else begin
                        i_cfg_valid <= 1'b0;
                    end
                end else begin
                    r = req_q.pop_front();
                    start          <= 1'b1;
                    i_command      <= r.cmd;
                    i_context_slot <= r.slot;
                    i_counter      <= r.ctr;
                    i_cfg_valid    <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        verdict_beat_t e;
        if (i_rst_n) begin
            if (limit_taken)
                live_limit = i_cfg_counter_limit;
            if (o_result_valid === 1'b1) begin
                if (awaited_verdicts.size() == 0) begin
                    $error("result beat with no item outstanding: verdict %0d, top %0h",
                           o_verdict, o_window_top);
                    mismatches++;
                end else begin
                    e = awaited_verdicts.pop_front();
                    if (o_verdict !== e.verdict) begin
                        $error("verdict: expected %0d, actual %0d", e.verdict, o_verdict);
                        mismatches++;
                    end
                    if (o_window_top !== e.top) begin
                        $error("window_top: expected %0h, actual %0h", e.top, o_window_top);
                        mismatches++;
                    end
                end
            end
            if (item_taken)
                awaited_verdicts.push_back(judge_frame(i_command, i_context_slot, i_counter));
        end
        if (item_taken || limit_taken || o_result_valid === 1'b1)
            stall = 0;
        else
            stall++;
        if (stall >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_counter all_ones;
        all_ones = '1;
        for (int i = 0; i < CONTEXTS_DEF; i++) begin
            slot_top[i]  = '0;
            slot_seen[i] = '0;
            guess_top[i] = '0;
        end

        add_limit(all_ones);
        add_frame(CMD_CHECK,  8'd0,   64'd0,   1'b0);
        add_frame(CMD_COMMIT, 8'd0,   64'd0,   1'b0);
        add_frame(CMD_CHECK,  8'd0,   64'd0,   1'b0);
        add_frame(CMD_COMMIT, 8'd1,   64'd100, 1'b0);
        add_frame(CMD_COMMIT, 8'd1,   64'd37,  1'b0);
        add_frame(CMD_COMMIT, 8'd1,   64'd36,  1'b0);
        add_frame(CMD_COMMIT, 8'd1,   64'd100, 1'b0);
        add_frame(CMD_CHECK,  8'd1,   64'd99,  1'b0);
        add_frame(CMD_COMMIT, 8'd1,   64'd200, 1'b0);
        add_frame(CMD_COMMIT, 8'd1,   64'd201, 1'b0);
        add_frame(CMD_CHECK,  8'd1,   64'd200, 1'b0);
        add_frame(CMD_UNUSED, 8'd1,   64'd202, 1'b0);
        add_frame(CMD_COMMIT, 8'd1,   64'd202, 1'b0);
        add_frame(CMD_CLEAR,  8'd1,   all_ones, 1'b0);
        add_frame(CMD_COMMIT, 8'd1,   64'd0,   1'b0);
        add_frame(CMD_COMMIT, 8'd255, all_ones, 1'b0);
        add_frame(CMD_COMMIT, 8'd255, 64'd0,   1'b0);
        add_frame(CMD_CHECK,  8'd255, all_ones - 64'd1, 1'b0);
        add_limit(64'd1000);
        add_frame(CMD_COMMIT, 8'd2,   64'd1001, 1'b0);
        add_frame(CMD_COMMIT, 8'd255, 64'd2000, 1'b0);
        add_frame(CMD_COMMIT, 8'd2,   64'd1000, 1'b0);
        add_limit(64'd0);
        add_frame(CMD_COMMIT, 8'd3,   64'd0,   1'b0);
        add_frame(CMD_COMMIT, 8'd3,   64'd1,   1'b0);
        add_frame(CMD_CLEAR,  8'd3,   64'd5,   1'b0);

        add_limit(all_ones);
        for (int i = 0; i < 150; i++)
            add_random_frame(!(i >= 50 && i < 110));
        add_limit(64'd0);
        for (int i = 0; i < 20; i++)
            add_random_frame(1'b1);
        add_limit(guess_top[51] + t_counter'($urandom_range(0, 100)));
        for (int i = 0; i < 100; i++)
            add_random_frame(1'b1);
        add_limit({$urandom, $urandom});
        for (int i = 0; i < 40; i++)
            add_random_frame(1'b1);
        add_limit(all_ones);
        for (int i = 0; i < 100; i++)
            add_random_frame(1'b1);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (req_q.size() != 0 || start || i_cfg_valid || awaited_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && awaited_verdicts.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: anti_replay_window_bank_unit.f
rtl/arwb_pkg.sv
rtl/arwb_store.sv
rtl/arwb_eval.sv
rtl/anti_replay_window_bank_unit.sv
rtl/arwb_checker.sv
tb/sv/anti_replay_window_bank_unit_tb.sv
